/* design/grr_pkg.sv */
`timescale 1ns / 1ps

package grr_pkg;

    // Register indexes (byte address 8*i)
    localparam logic [2:0] REG_RX    = 3'd0;
    localparam logic [2:0] REG_RY    = 3'd1;
    localparam logic [2:0] REG_RZ    = 3'd2;
    localparam logic [2:0] REG_BIAS  = 3'd3;
    localparam logic [2:0] REG_VX    = 3'd4;
    localparam logic [2:0] REG_VY    = 3'd5;
    localparam logic [2:0] REG_VZ    = 3'd6;
    localparam logic [2:0] REG_DRIFT = 3'd7;

    // Root: 98-bit sum of squares, 49-bit root, one result bit per stage
    localparam int SQ_STEPS = 49;
    // Divider: 82-bit dividend, quotient proven below 2^35
    localparam int DIV_STEPS = 35;

    typedef struct packed {
        logic [81:0]        dot_mag;
        logic               dot_neg;
        logic signed [48:0] rng_base;   // measured_range - clock_bias
        logic signed [33:0] rate_base;  // measured_rate - clock_drift
        logic               last;
    } grr_sq_side_t;

    typedef struct packed {
        logic signed [47:0] range_res;
        logic               zero;
        logic               dot_neg;
        logic signed [33:0] rate_base;
        logic               last;
    } grr_div_side_t;

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if ((v[50:47] == 4'b0000) || (v[50:47] == 4'b1111))
        begin
            r = v[47:0];
        end
        else if (v[50])
        begin
            r = {1'b1, 47'd0};
        end
        else
        begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111))
        begin
            r = v[31:0];
        end
        else if (v[36])
        begin
            r = {1'b1, 31'd0};
        end
        else
        begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

/* design/grr_in_if.sv */
`timescale 1ns / 1ps

interface grr_in_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] sat_x;
    logic signed [47:0] sat_y;
    logic signed [47:0] sat_z;
    logic signed [31:0] sat_vx;
    logic signed [31:0] sat_vy;
    logic signed [31:0] sat_vz;
    logic signed [47:0] measured_range;
    logic signed [31:0] measured_rate;
    logic               last_sat;

    modport source (
        output valid, sat_x, sat_y, sat_z, sat_vx, sat_vy, sat_vz,
               measured_range, measured_rate, last_sat,
        input  ready
    );
    modport sink (
        input  valid, sat_x, sat_y, sat_z, sat_vx, sat_vy, sat_vz,
               measured_range, measured_rate, last_sat,
        output ready
    );
endinterface

/* design/grr_out_if.sv */
`timescale 1ns / 1ps

interface grr_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] range_residual;
    logic signed [31:0] rate_residual;
    logic               range_zero;
    logic               last_out;

    modport source (
        output valid, range_residual, rate_residual, range_zero, last_out,
        input  ready
    );
    modport sink (
        input  valid, range_residual, rate_residual, range_zero, last_out,
        output ready
    );
endinterface

/* design/grr_mul.sv */
`timescale 1ns / 1ps

// 49x49 unsigned multiply: partial products, then sum (two stages)
module grr_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [48:0] a,
    input  logic [48:0] b,
    output logic [97:0] p
);
    logic [49:0] pp00_reg;
    logic [48:0] pp01_reg;
    logic [48:0] pp10_reg;
    logic [47:0] pp11_reg;
    logic [97:0] p_reg;

    logic [49:0] pp00_next;
    logic [48:0] pp01_next;
    logic [48:0] pp10_next;
    logic [47:0] pp11_next;
    logic [97:0] p_next;

    always_comb
    begin
        pp00_next = 50'(a[24:0]) * 50'(b[24:0]);
        pp01_next = 49'(a[24:0]) * 49'(b[48:25]);
        pp10_next = 49'(a[48:25]) * 49'(b[24:0]);
        pp11_next = 48'(a[48:25]) * 48'(b[48:25]);
        p_next = 98'(pp00_reg) + (98'(pp01_reg) << 25) + (98'(pp10_reg) << 25)
               + (98'(pp11_reg) << 50);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;
endmodule

/* design/grr_sqrt.sv */
`timescale 1ns / 1ps

// Pipelined digit-by-digit integer square root, one root bit per stage
module grr_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [97:0]          s_in,
    input  grr_pkg::grr_sq_side_t side_in,
    output logic                 out_valid,
    output logic [48:0]          root,
    output grr_pkg::grr_sq_side_t side_out
);
    localparam int N = grr_pkg::SQ_STEPS;

    logic                  valid_reg [N];
    logic [97:0]           s_reg     [N];
    logic [50:0]           rem_reg   [N];
    logic [48:0]           root_reg  [N];
    grr_pkg::grr_sq_side_t side_reg  [N];

    logic                  valid_next [N];
    logic [97:0]           s_next     [N];
    logic [50:0]           rem_next   [N];
    logic [48:0]           root_next  [N];
    grr_pkg::grr_sq_side_t side_next  [N];

    always_comb
    begin
        logic [97:0] s_p;
        logic [50:0] rem_p;
        logic [48:0] root_p;
        logic [52:0] tmp;
        logic [52:0] trial;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                side_next[k]  = side_in;
                s_p    = s_in;
                rem_p  = '0;
                root_p = '0;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                side_next[k]  = side_reg[k-1];
                s_p    = s_reg[k-1];
                rem_p  = rem_reg[k-1];
                root_p = root_reg[k-1];
            end
            tmp   = {rem_p, s_p[97:96]};
            trial = {2'b00, root_p, 2'b01};
            if (tmp >= trial)
            begin
                rem_next[k]  = 51'(tmp - trial);
                root_next[k] = {root_p[47:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = 51'(tmp);
                root_next[k] = {root_p[47:0], 1'b0};
            end
            s_next[k] = {s_p[95:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                s_reg[k]    <= s_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];
endmodule

/* design/grr_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Dividend high part must be below the divisor (quotient < 2^35).
module grr_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [81:0]           n_in,
    input  logic [48:0]           d_in,
    input  grr_pkg::grr_div_side_t side_in,
    output logic                  out_valid,
    output logic [34:0]           quo,
    output grr_pkg::grr_div_side_t side_out
);
    localparam int N = grr_pkg::DIV_STEPS;

    logic                   valid_reg [N];
    logic [48:0]            rem_reg   [N];
    logic [34:0]            nlo_reg   [N];
    logic [34:0]            q_reg     [N];
    logic [48:0]            d_reg     [N];
    grr_pkg::grr_div_side_t side_reg  [N];

    logic                   valid_next [N];
    logic [48:0]            rem_next   [N];
    logic [34:0]            nlo_next   [N];
    logic [34:0]            q_next     [N];
    logic [48:0]            d_next     [N];
    grr_pkg::grr_div_side_t side_next  [N];

    always_comb
    begin
        logic [48:0] rem_p;
        logic [34:0] nlo_p;
        logic [34:0] q_p;
        logic [49:0] tmp;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                side_next[k]  = side_in;
                d_next[k]     = d_in;
                rem_p = {2'b00, n_in[81:35]};
                nlo_p = n_in[34:0];
                q_p   = '0;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                side_next[k]  = side_reg[k-1];
                d_next[k]     = d_reg[k-1];
                rem_p = rem_reg[k-1];
                nlo_p = nlo_reg[k-1];
                q_p   = q_reg[k-1];
            end
            tmp = {rem_p, nlo_p[34]};
            if (tmp >= {1'b0, d_next[k]})
            begin
                rem_next[k] = 49'(tmp - {1'b0, d_next[k]});
                q_next[k]   = {q_p[33:0], 1'b1};
            end
            else
            begin
                rem_next[k] = 49'(tmp);
                q_next[k]   = {q_p[33:0], 1'b0};
            end
            nlo_next[k] = {nlo_p[33:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                nlo_reg[k]  <= nlo_next[k];
                q_reg[k]    <= q_next[k];
                d_reg[k]    <= d_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quo       = q_reg[N-1];
    assign side_out  = side_reg[N-1];
endmodule

/* design/gnss_range_and_rate_residual.sv */
`timescale 1ns / 1ps

// GNSS pseudorange and range-rate residual pipeline. One satellite transaction
// enters per cycle while the pipeline is not held, and gives one result
// transaction after the differences, 49x49 partial-product multiplies and sums,
// the bit-per-stage square root, the range residual, the
// bit-per-stage divider and the output register. The whole pipeline moves as
// one; it holds when the output register is full and not taken, so in_ch.ready
// follows out_ch.ready. All values are two's complement with 16 fraction bits;
// range = floor(sqrt(dx^2+dy^2+dz^2)), quotient truncated toward zero, both
// residuals saturated. A zero range raises range_zero and gives a zero rate
// residual. Receiver registers sit at byte address 8*i on the APB port and must
// only be written while no transaction is in flight.
module gnss_range_and_rate_residual (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    grr_in_if.sink      in_ch,
    grr_out_if.source   out_ch
);
    // ---------------- configuration ----------------
    logic signed [47:0] rx_reg, ry_reg, rz_reg, bias_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg, drift_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg    <= '0;
            ry_reg    <= '0;
            rz_reg    <= '0;
            bias_reg  <= '0;
            vx_reg    <= '0;
            vy_reg    <= '0;
            vz_reg    <= '0;
            drift_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                grr_pkg::REG_RX:    rx_reg    <= pwdata[47:0];
                grr_pkg::REG_RY:    ry_reg    <= pwdata[47:0];
                grr_pkg::REG_RZ:    rz_reg    <= pwdata[47:0];
                grr_pkg::REG_BIAS:  bias_reg  <= pwdata[47:0];
                grr_pkg::REG_VX:    vx_reg    <= pwdata[31:0];
                grr_pkg::REG_VY:    vy_reg    <= pwdata[31:0];
                grr_pkg::REG_VZ:    vz_reg    <= pwdata[31:0];
                grr_pkg::REG_DRIFT: drift_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            grr_pkg::REG_RX:    prdata = {16'd0, rx_reg};
            grr_pkg::REG_RY:    prdata = {16'd0, ry_reg};
            grr_pkg::REG_RZ:    prdata = {16'd0, rz_reg};
            grr_pkg::REG_BIAS:  prdata = {16'd0, bias_reg};
            grr_pkg::REG_VX:    prdata = {32'd0, vx_reg};
            grr_pkg::REG_VY:    prdata = {32'd0, vy_reg};
            grr_pkg::REG_VZ:    prdata = {32'd0, vz_reg};
            grr_pkg::REG_DRIFT: prdata = {32'd0, drift_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- global advance ----------------
    // Every stage shifts together when the output slot is free or being taken.
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // ---------------- stage A: differences ----------------
    logic               a_valid_reg;
    logic signed [48:0] a_dx_reg, a_dy_reg, a_dz_reg;
    logic signed [32:0] a_dvx_reg, a_dvy_reg, a_dvz_reg;
    logic signed [48:0] a_rng_reg;   // measured range minus bias
    logic signed [33:0] a_rate_reg;  // measured rate minus drift
    logic               a_last_reg;

    // ---------------- stage B: magnitudes and signs ----------------
    logic               b_valid_reg;
    logic [48:0]        b_mx_reg, b_my_reg, b_mz_reg;
    logic [32:0]        b_mvx_reg, b_mvy_reg, b_mvz_reg;
    logic [2:0]         b_neg_reg;
    logic signed [48:0] b_rng_reg;
    logic signed [33:0] b_rate_reg;
    logic               b_last_reg;

    // side data riding along the two multiplier stages
    logic               m1_valid_reg, m2_valid_reg;
    logic [2:0]         m1_neg_reg, m2_neg_reg;
    logic signed [48:0] m1_rng_reg, m2_rng_reg;
    logic signed [33:0] m1_rate_reg, m2_rate_reg;
    logic               m1_last_reg, m2_last_reg;

    logic [97:0] sqx, sqy, sqz, px, py, pz;

    // ---------------- stage C1/C2/D ----------------
    logic               c1_valid_reg;
    logic [97:0]        c1_sq_reg;
    logic signed [82:0] c1_sp_reg [3];
    logic signed [48:0] c1_rng_reg;
    logic signed [33:0] c1_rate_reg;
    logic               c1_last_reg;

    logic               c2_valid_reg;
    logic [97:0]        c2_sq_reg;
    logic signed [82:0] c2_dot_reg;
    logic signed [48:0] c2_rng_reg;
    logic signed [33:0] c2_rate_reg;
    logic               c2_last_reg;

    logic                  d_valid_reg;
    logic [97:0]           d_sq_reg;
    grr_pkg::grr_sq_side_t d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            d_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg  <= in_ch.valid;
            b_valid_reg  <= a_valid_reg;
            m1_valid_reg <= b_valid_reg;
            m2_valid_reg <= m1_valid_reg;
            c1_valid_reg <= m2_valid_reg;
            c2_valid_reg <= c1_valid_reg;
            d_valid_reg  <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A
            a_dx_reg   <= 49'(in_ch.sat_x) - 49'(rx_reg);
            a_dy_reg   <= 49'(in_ch.sat_y) - 49'(ry_reg);
            a_dz_reg   <= 49'(in_ch.sat_z) - 49'(rz_reg);
            a_dvx_reg  <= 33'(in_ch.sat_vx) - 33'(vx_reg);
            a_dvy_reg  <= 33'(in_ch.sat_vy) - 33'(vy_reg);
            a_dvz_reg  <= 33'(in_ch.sat_vz) - 33'(vz_reg);
            a_rng_reg  <= 49'(in_ch.measured_range) - 49'(bias_reg);
            a_rate_reg <= 34'(in_ch.measured_rate) - 34'(drift_reg);
            a_last_reg <= in_ch.last_sat;
            // B
            b_mx_reg   <= a_dx_reg[48] ? 49'(-a_dx_reg) : 49'(a_dx_reg);
            b_my_reg   <= a_dy_reg[48] ? 49'(-a_dy_reg) : 49'(a_dy_reg);
            b_mz_reg   <= a_dz_reg[48] ? 49'(-a_dz_reg) : 49'(a_dz_reg);
            b_mvx_reg  <= a_dvx_reg[32] ? 33'(-a_dvx_reg) : 33'(a_dvx_reg);
            b_mvy_reg  <= a_dvy_reg[32] ? 33'(-a_dvy_reg) : 33'(a_dvy_reg);
            b_mvz_reg  <= a_dvz_reg[32] ? 33'(-a_dvz_reg) : 33'(a_dvz_reg);
            b_neg_reg  <= {a_dz_reg[48] ^ a_dvz_reg[32],
                           a_dy_reg[48] ^ a_dvy_reg[32],
                           a_dx_reg[48] ^ a_dvx_reg[32]};
            b_rng_reg  <= a_rng_reg;
            b_rate_reg <= a_rate_reg;
            b_last_reg <= a_last_reg;
            // multiplier side data
            m1_neg_reg  <= b_neg_reg;
            m1_rng_reg  <= b_rng_reg;
            m1_rate_reg <= b_rate_reg;
            m1_last_reg <= b_last_reg;
            m2_neg_reg  <= m1_neg_reg;
            m2_rng_reg  <= m1_rng_reg;
            m2_rate_reg <= m1_rate_reg;
            m2_last_reg <= m1_last_reg;
            // C1: sum of squares, signed dot terms (each below 2^81)
            c1_sq_reg    <= sqx + sqy + sqz;
            c1_sp_reg[0] <= m2_neg_reg[0] ? -$signed({1'b0, px[81:0]})
                                          : $signed({1'b0, px[81:0]});
            c1_sp_reg[1] <= m2_neg_reg[1] ? -$signed({1'b0, py[81:0]})
                                          : $signed({1'b0, py[81:0]});
            c1_sp_reg[2] <= m2_neg_reg[2] ? -$signed({1'b0, pz[81:0]})
                                          : $signed({1'b0, pz[81:0]});
            c1_rng_reg   <= m2_rng_reg;
            c1_rate_reg  <= m2_rate_reg;
            c1_last_reg  <= m2_last_reg;
            // C2: dot product
            c2_sq_reg   <= c1_sq_reg;
            c2_dot_reg  <= c1_sp_reg[0] + c1_sp_reg[1] + c1_sp_reg[2];
            c2_rng_reg  <= c1_rng_reg;
            c2_rate_reg <= c1_rate_reg;
            c2_last_reg <= c1_last_reg;
            // D: sign-magnitude split of the dot product
            d_sq_reg             <= c2_sq_reg;
            d_side_reg.dot_mag   <= c2_dot_reg[82] ? 82'(-c2_dot_reg) : 82'(c2_dot_reg);
            d_side_reg.dot_neg   <= c2_dot_reg[82];
            d_side_reg.rng_base  <= c2_rng_reg;
            d_side_reg.rate_base <= c2_rate_reg;
            d_side_reg.last      <= c2_last_reg;
        end
    end

    grr_mul u_mul_x (.clk(clk), .en(en), .a(b_mx_reg), .b(b_mx_reg), .p(sqx));
    grr_mul u_mul_y (.clk(clk), .en(en), .a(b_my_reg), .b(b_my_reg), .p(sqy));
    grr_mul u_mul_z (.clk(clk), .en(en), .a(b_mz_reg), .b(b_mz_reg), .p(sqz));
    grr_mul u_dot_x (.clk(clk), .en(en), .a(b_mx_reg), .b({16'd0, b_mvx_reg}), .p(px));
    grr_mul u_dot_y (.clk(clk), .en(en), .a(b_my_reg), .b({16'd0, b_mvy_reg}), .p(py));
    grr_mul u_dot_z (.clk(clk), .en(en), .a(b_mz_reg), .b({16'd0, b_mvz_reg}), .p(pz));

    // ---------------- square root ----------------
    logic                  sq_valid;
    logic [48:0]           sq_root;
    grr_pkg::grr_sq_side_t sq_side;

    grr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid_reg),
        .s_in     (d_sq_reg),
        .side_in  (d_side_reg),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // ---------------- stage F: range residual ----------------
    logic                   f_valid_reg;
    logic [81:0]            f_n_reg;
    logic [48:0]            f_d_reg;
    grr_pkg::grr_div_side_t f_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_n_reg              <= sq_side.dot_mag;
            f_d_reg              <= sq_root;
            f_side_reg.range_res <= grr_pkg::sat48(51'(sq_side.rng_base)
                                                   - $signed({2'b00, sq_root}));
            f_side_reg.zero      <= (sq_root == '0);
            f_side_reg.dot_neg   <= sq_side.dot_neg;
            f_side_reg.rate_base <= sq_side.rate_base;
            f_side_reg.last      <= sq_side.last;
        end
    end

    // ---------------- divider ----------------
    // |dot|/R stays below 2|dv|, so 35 quotient bits hold it.
    logic                   dv_valid;
    logic [34:0]            dv_quo;
    grr_pkg::grr_div_side_t dv_side;

    grr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid_reg),
        .n_in     (f_n_reg),
        .d_in     (f_d_reg),
        .side_in  (f_side_reg),
        .out_valid(dv_valid),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    // ---------------- output register ----------------
    logic signed [47:0] out_range_reg;
    logic signed [31:0] out_rate_reg;
    logic               out_zero_reg;
    logic               out_last_reg;
    logic signed [36:0] rate_wide;

    always_comb
    begin
        if (dv_side.dot_neg)
        begin
            rate_wide = 37'(dv_side.rate_base) + $signed({2'b00, dv_quo});
        end
        else
        begin
            rate_wide = 37'(dv_side.rate_base) - $signed({2'b00, dv_quo});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_range_reg <= dv_side.range_res;
            out_rate_reg  <= dv_side.zero ? 32'sd0 : grr_pkg::sat32(rate_wide);
            out_zero_reg  <= dv_side.zero;
            out_last_reg  <= dv_side.last;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.range_residual = out_range_reg;
    assign out_ch.rate_residual  = out_rate_reg;
    assign out_ch.range_zero     = out_zero_reg;
    assign out_ch.last_out       = out_last_reg;

    // ---------------- assertions ----------------
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.range_zero |-> out_ch.rate_residual == 32'sd0)
        else $error("rate residual not zero on zero range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> a_valid_reg)
        else $error("accepted transaction missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(d_valid_reg) && $stable(f_valid_reg))
        else $error("pipeline moved during stall");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg && en |-> f_side_reg.zero == (f_d_reg == '0))
        else $error("zero flag disagrees with root");
endmodule

/* test/gnss_range_and_rate_residual_tb.sv */
`timescale 1ns / 1ps

module gnss_range_and_rate_residual_tb;

    localparam int LATENCY   = 93;
    localparam int SETTLE    = LATENCY + 20;
    localparam int STALL_MAX = 6000;   // cycles without any transaction
    localparam int HOLD_LEN  = 400;    // long receiver hold-off

    typedef struct {
        logic signed [47:0] sat_x, sat_y, sat_z;
        logic signed [31:0] sat_vx, sat_vy, sat_vz;
        logic signed [47:0] measured_range;
        logic signed [31:0] measured_rate;
        logic               last_sat;
    } sat_item_t;

    typedef struct {
        logic signed [47:0] range_residual;
        logic signed [31:0] rate_residual;
        logic               range_zero;
        logic               last_out;
    } residual_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    grr_in_if  in_ch ();
    grr_out_if out_ch ();

    gnss_range_and_rate_residual u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #4 clk = ~clk;

    // Shadow of the receiver registers, by register index
    logic [63:0] rcv_regs [8];

    sat_item_t pending_sats[$];
    residual_t expected_residuals[$];

    int  errors = 0;
    int  results_seen = 0;
    logic in_took = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    // ---------------------------------------------------------------------
    // Predictor: exact wide arithmetic, floor root, truncating quotient
    // ---------------------------------------------------------------------
    function automatic logic [63:0] clamp_to(logic signed [127:0] v, int w);
        logic signed [127:0] hi, lo;
        hi = (128'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[63:0];
    endfunction

    function automatic residual_t residual_of(sat_item_t it);
        logic signed [127:0] dx, dy, dz, dvx, dvy, dvz, rs, dot, quo, rr, vr;
        logic [127:0] sq, c;
        logic [63:0] root;
        logic [63:0] sr, sv;
        residual_t res;
        dx  = 128'(it.sat_x)  - 128'($signed(rcv_regs[grr_pkg::REG_RX][47:0]));
        dy  = 128'(it.sat_y)  - 128'($signed(rcv_regs[grr_pkg::REG_RY][47:0]));
        dz  = 128'(it.sat_z)  - 128'($signed(rcv_regs[grr_pkg::REG_RZ][47:0]));
        dvx = 128'(it.sat_vx) - 128'($signed(rcv_regs[grr_pkg::REG_VX][31:0]));
        dvy = 128'(it.sat_vy) - 128'($signed(rcv_regs[grr_pkg::REG_VY][31:0]));
        dvz = 128'(it.sat_vz) - 128'($signed(rcv_regs[grr_pkg::REG_VZ][31:0]));
        sq = dx * dx + dy * dy + dz * dz;
        root = '0;
        for (int i = 62; i >= 0; i--)
        begin
            c = {64'd0, root | (64'd1 << i)};
            if (c * c <= sq) root = c[63:0];
        end
        rs = {64'd0, root};
        rr = 128'(it.measured_range) - rs
           - 128'($signed(rcv_regs[grr_pkg::REG_BIAS][47:0]));
        sr = clamp_to(rr, 48);
        res.range_residual = sr[47:0];
        res.range_zero = (root == 0);
        res.last_out = it.last_sat;
        if (root == 0)
        begin
            res.rate_residual = '0;   // zero range forces a zero rate residual
        end
        else
        begin
            dot = dvx * dx + dvy * dy + dvz * dz;
            quo = dot / rs;           // signed divide truncates toward zero
            vr = 128'(it.measured_rate) - quo
               - 128'($signed(rcv_regs[grr_pkg::REG_DRIFT][31:0]));
            sv = clamp_to(vr, 32);
            res.rate_residual = sv[31:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------------
    // random signed value carrying k significant bits
    function automatic logic signed [47:0] rnd48(int k);
        logic signed [47:0] v;
        v = 48'({$urandom, $urandom});
        return v >>> (48 - k);
    endfunction

    function automatic logic signed [31:0] rnd32(int k);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - k);
    endfunction

    // ---------------------------------------------------------------------
    // APB write: setup cycle then access cycle, launched on falling edges
    // ---------------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rcv_regs[idx] = (idx < grr_pkg::REG_VX) ? {16'd0, val[47:0]} : {32'd0, val[31:0]};
    endtask

    task automatic load_receiver(logic [47:0] x, logic [47:0] y, logic [47:0] z,
                                 logic [47:0] b, logic [31:0] vx, logic [31:0] vy,
                                 logic [31:0] vz, logic [31:0] d);
        reg_write(grr_pkg::REG_RX, {16'd0, x});
        reg_write(grr_pkg::REG_RY, {16'd0, y});
        reg_write(grr_pkg::REG_RZ, {16'd0, z});
        reg_write(grr_pkg::REG_BIAS, {16'd0, b});
        reg_write(grr_pkg::REG_VX, {32'd0, vx});
        reg_write(grr_pkg::REG_VY, {32'd0, vy});
        reg_write(grr_pkg::REG_VZ, {32'd0, vz});
        reg_write(grr_pkg::REG_DRIFT, {32'd0, d});
    endtask

    // satellite at a random offset from the receiver, random content
    function automatic sat_item_t near_sat();
        sat_item_t s;
        int k;
        k = $urandom_range(1, 44);
        s.sat_x = $signed(rcv_regs[grr_pkg::REG_RX][47:0]) + rnd48(k);
        s.sat_y = $signed(rcv_regs[grr_pkg::REG_RY][47:0]) + rnd48(k);
        s.sat_z = $signed(rcv_regs[grr_pkg::REG_RZ][47:0]) + rnd48(k);
        s.sat_vx = rnd32($urandom_range(1, 32));
        s.sat_vy = rnd32($urandom_range(1, 32));
        s.sat_vz = rnd32($urandom_range(1, 32));
        s.measured_range = rnd48($urandom_range(1, 48));
        s.measured_rate = rnd32($urandom_range(1, 32));
        s.last_sat = ($urandom_range(0, 7) == 0);
        return s;
    endfunction

    function automatic sat_item_t wild_sat();
        sat_item_t s;
        s.sat_x = rnd48(48);
        s.sat_y = rnd48(48);
        s.sat_z = rnd48(48);
        s.sat_vx = $urandom;
        s.sat_vy = $urandom;
        s.sat_vz = $urandom;
        s.measured_range = rnd48(48);
        s.measured_rate = $urandom;
        s.last_sat = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic queue_random(int n);
        sat_item_t s;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0:       begin s = near_sat(); // coincident with receiver
                               s.sat_x = rcv_regs[grr_pkg::REG_RX][47:0];
                               s.sat_y = rcv_regs[grr_pkg::REG_RY][47:0];
                               s.sat_z = rcv_regs[grr_pkg::REG_RZ][47:0]; end
                1, 2, 3: s = wild_sat();
                default: s = near_sat();
            endcase
            pending_sats.push_back(s);
        end
    endtask

    // Directed corner cases under the current receiver setting
    task automatic queue_directed();
        sat_item_t s;
        logic signed [47:0] mx48, mn48;
        logic signed [31:0] mx32, mn32;
        mx48 = {1'b0, {47{1'b1}}};
        mn48 = {1'b1, 47'd0};
        mx32 = {1'b0, {31{1'b1}}};
        mn32 = {1'b1, 31'd0};
        // zero range: satellite sits on the receiver
        s = near_sat();
        s.sat_x = rcv_regs[grr_pkg::REG_RX][47:0];
        s.sat_y = rcv_regs[grr_pkg::REG_RY][47:0];
        s.sat_z = rcv_regs[grr_pkg::REG_RZ][47:0];
        s.last_sat = 1'b1;
        pending_sats.push_back(s);
        // all fields at their maxima, then minima
        s = '{mx48, mx48, mx48, mx32, mx32, mx32, mx48, mx32, 1'b1};
        pending_sats.push_back(s);
        s = '{mn48, mn48, mn48, mn32, mn32, mn32, mn48, mn32, 1'b0};
        pending_sats.push_back(s);
        // mixed extremes drive both residuals into saturation
        s = '{mx48, mn48, mx48, mn32, mx32, mn32, mn48, mx32, 1'b0};
        pending_sats.push_back(s);
        s = '{mn48, mx48, mn48, mx32, mn32, mx32, mx48, mn32, 1'b1};
        pending_sats.push_back(s);
        // unit offset along each axis: smallest nonzero range
        for (int a = 0; a < 3; a++)
        begin
            s = near_sat();
            s.sat_x = $signed(rcv_regs[grr_pkg::REG_RX][47:0])
                    + ((a == 0) ? 48'sd1 : 48'sd0);
            s.sat_y = $signed(rcv_regs[grr_pkg::REG_RY][47:0])
                    + ((a == 1) ? 48'sd1 : 48'sd0);
            s.sat_z = $signed(rcv_regs[grr_pkg::REG_RZ][47:0])
                    - ((a == 2) ? 48'sd1 : 48'sd0);
            pending_sats.push_back(s);
        end
        queue_random(10);
    endtask

    task automatic drain_phase();
        while (pending_sats.size() != 0 || in_ch.valid) @(posedge clk);
        while (expected_residuals.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Driver: one satellite transaction at a time, changes on falling edge
    // ---------------------------------------------------------------------
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.sat_x = '0; in_ch.sat_y = '0; in_ch.sat_z = '0;
        in_ch.sat_vx = '0; in_ch.sat_vy = '0; in_ch.sat_vz = '0;
        in_ch.measured_range = '0; in_ch.measured_rate = '0;
        in_ch.last_sat = 1'b0;
        out_ch.ready = 1'b0;
    end

    // no idling on either side within this window
    function automatic bit busy_window();
        return results_seen >= 300 && results_seen < 450;
    endfunction

    always @(negedge clk)
    begin
        sat_item_t s;
        if (rst_n && (!in_ch.valid || in_took))
        begin
            if (pending_sats.size() != 0 && (busy_window() || $urandom_range(0, 99) >= 17))
            begin
                s = pending_sats.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.sat_x <= s.sat_x;
                in_ch.sat_y <= s.sat_y;
                in_ch.sat_z <= s.sat_z;
                in_ch.sat_vx <= s.sat_vx;
                in_ch.sat_vy <= s.sat_vy;
                in_ch.sat_vz <= s.sat_vz;
                in_ch.measured_range <= s.measured_range;
                in_ch.measured_rate <= s.measured_rate;
                in_ch.last_sat <= s.last_sat;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready: random idling plus one long hold-off so the pipe fills
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && pending_sats.size() >= 95)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= busy_window() || ($urandom_range(0, 99) >= 17);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predict on input transaction, check on output transaction
    // ---------------------------------------------------------------------
    int quiet = 0;

    always @(posedge clk)
    begin
        sat_item_t s;
        residual_t exp_r;
        in_took <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready)
        begin
            s = '{in_ch.sat_x, in_ch.sat_y, in_ch.sat_z, in_ch.sat_vx, in_ch.sat_vy,
                  in_ch.sat_vz, in_ch.measured_range, in_ch.measured_rate, in_ch.last_sat};
            expected_residuals.push_back(residual_of(s));
        end
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_residuals.size() == 0)
            begin
                $error("unexpected result transaction");
                errors = errors + 1;
            end
            else
            begin
                exp_r = expected_residuals.pop_front();
                if (out_ch.range_residual !== exp_r.range_residual)
                begin
                    $error("range_residual expected %0d got %0d",
                           exp_r.range_residual, out_ch.range_residual);
                    errors = errors + 1;
                end
                if (out_ch.rate_residual !== exp_r.rate_residual)
                begin
                    $error("rate_residual expected %0d got %0d",
                           exp_r.rate_residual, out_ch.rate_residual);
                    errors = errors + 1;
                end
                if (out_ch.range_zero !== exp_r.range_zero)
                begin
                    $error("range_zero expected %0b got %0b",
                           exp_r.range_zero, out_ch.range_zero);
                    errors = errors + 1;
                end
                if (out_ch.last_out !== exp_r.last_out)
                begin
                    $error("last_out expected %0b got %0b",
                           exp_r.last_out, out_ch.last_out);
                    errors = errors + 1;
                end
            end
        end
        // watchdog: too long with no transaction on either channel
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= STALL_MAX)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence of receiver settings; each phase drains before the next write
    // ---------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < 8; i++) rcv_regs[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // receiver at origin, no bias or drift
        load_receiver('0, '0, '0, '0, '0, '0, '0, '0);
        queue_directed();
        queue_random(80);
        drain_phase();

        // every register at its maximum
        load_receiver({1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}},
                      {1'b0, {47{1'b1}}}, {1'b0, {31{1'b1}}}, {1'b0, {31{1'b1}}},
                      {1'b0, {31{1'b1}}}, {1'b0, {31{1'b1}}});
        queue_directed();
        queue_random(60);
        drain_phase();

        // every register at its minimum
        load_receiver({1'b1, 47'd0}, {1'b1, 47'd0}, {1'b1, 47'd0}, {1'b1, 47'd0},
                      {1'b1, 31'd0}, {1'b1, 31'd0}, {1'b1, 31'd0}, {1'b1, 31'd0});
        queue_directed();
        queue_random(60);
        drain_phase();

        // random receiver states, sizes from small to full width
        for (int p = 0; p < 3; p++)
        begin
            load_receiver(rnd48(24 + 12 * p), rnd48(24 + 12 * p), rnd48(24 + 12 * p),
                          rnd48($urandom_range(1, 48)), rnd32($urandom_range(1, 32)),
                          rnd32($urandom_range(1, 32)), rnd32($urandom_range(1, 32)),
                          rnd32($urandom_range(1, 32)));
            queue_random(100);
            drain_phase();
        end

        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/grr_pkg.sv
design/grr_in_if.sv
design/grr_out_if.sv
design/grr_mul.sv
design/grr_sqrt.sv
design/grr_div.sv
design/gnss_range_and_rate_residual.sv
test/gnss_range_and_rate_residual_tb.sv
